>>> rtl/core/jbt_pkg.sv
// ----------------------------------------------------------------------------
// jbt_pkg
// Shared types and constants for the JSON byte tokenizer.
// ----------------------------------------------------------------------------
package jbt_pkg;

  localparam int MAX_TOKENS_DEF = 256;
  localparam int POS_BITS_DEF   = 16;
  localparam int QDEPTH         = 4;
  localparam int QPTR_W         = $clog2(QDEPTH);
  localparam int REGS_PER_GRP   = 3;

  // record kinds
  localparam logic [1:0] RK_TOKEN = 2'd0;
  localparam logic [1:0] RK_CLOSE = 2'd1;
  localparam logic [1:0] RK_DONE  = 2'd2;
  localparam logic [1:0] RK_ERROR = 2'd3;

  // token kinds
  localparam logic [1:0] TK_OBJECT = 2'd0;
  localparam logic [1:0] TK_ARRAY  = 2'd1;
  localparam logic [1:0] TK_STRING = 2'd2;
  localparam logic [1:0] TK_PRIM   = 2'd3;

  // error codes
  localparam logic [1:0] ERR_SLOTS   = 2'd0;
  localparam logic [1:0] ERR_STRING  = 2'd1;
  localparam logic [1:0] ERR_TOOLONG = 2'd2;

  // characters
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // config register index
  localparam logic REG_TOKEN_LIMIT = 1'b0;
  localparam logic [8:0] TOKEN_LIMIT_RST = 9'd256;

  typedef struct packed {
    logic [1:0]  rkind;
    logic [7:0]  idx;
    logic [1:0]  tkind;
    logic [15:0] spos;
    logic [16:0] epos;
    logic        eknown;
    logic [8:0]  total;
    logic [1:0]  ecode;
  } jbt_rec_t;

  // records caused by one input byte
  typedef struct packed {
    logic [1:0]            cnt;
    jbt_rec_t [2:0]        recs;
  } jbt_grp_t;

endpackage

>>> rtl/core/jbt_ifs.sv
// ----------------------------------------------------------------------------
// jbt stream interfaces
// Valid/ready channels for text bytes in and token records out.
// ----------------------------------------------------------------------------
interface jbt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, text_byte, end_of_text, input ready);
  modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

interface jbt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  record_kind;
  logic [7:0]  token_index;
  logic [1:0]  token_kind;
  logic [15:0] start_pos;
  logic [16:0] end_pos;
  logic        end_known;
  logic [8:0]  token_total;
  logic [1:0]  error_code;
  logic        last_of_run;

  modport source (output valid, record_kind, token_index, token_kind, start_pos, end_pos,
                  end_known, token_total, error_code, last_of_run, input ready);
  modport sink   (input valid, record_kind, token_index, token_kind, start_pos, end_pos,
                  end_known, token_total, error_code, last_of_run, output ready);
endinterface

>>> rtl/core/jbt_ram.sv
// ----------------------------------------------------------------------------
// jbt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module jbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/jbt_front.sv
// ----------------------------------------------------------------------------
// jbt_front
// Byte classifier and parser state; builds the record group for each byte.
// ----------------------------------------------------------------------------
module jbt_front import jbt_pkg::*; #(
  parameter int MAX_TOKENS = MAX_TOKENS_DEF,
  parameter int POS_BITS   = POS_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] text_byte,
  input  logic       end_of_text,
  input  logic [8:0] token_limit,
  output logic       grp_valid,
  output jbt_grp_t   grp,
  input  logic       grp_ready
);

  localparam int SW = $clog2(MAX_TOKENS + 1);
  localparam int AW = MAX_TOKENS > 1 ? $clog2(MAX_TOKENS) : 1;
  localparam int CW = SW > 9 ? SW : 9;

  typedef enum logic [3:0] {
    MODE_NORMAL = 4'b0001,
    MODE_STRING = 4'b0010,
    MODE_PRIM   = 4'b0100,
    MODE_DROP   = 4'b1000
  } jbt_mode_t;

  jbt_mode_t           mode_r, mode_nxt;
  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic [POS_BITS-1:0] item_r, item_nxt;
  logic [SW-1:0]       slot_r, slot_nxt;
  logic [SW-1:0]       depth_r, depth_nxt;

  logic                s1_valid_r;
  jbt_grp_t            s1_grp_r;
  logic [2:0]          s1_stk_r;

  logic [POS_BITS:0]   p1;
  logic                is_open, is_close, is_quote, is_ws, ends_prim;
  logic                do_create, cknown, close_req, full, fail_slots, pop, push, failed;
  logic [1:0]          ck;
  logic [POS_BITS-1:0] cs;
  logic [POS_BITS:0]   ce;
  jbt_grp_t            grp_c;
  logic [2:0]          stk_c;
  logic                acc;
  logic [7:0]          stk_rdata;

  assign p1        = {1'b0, pos_r} + 1'b1;
  assign is_open   = (text_byte == CH_LBRACE) || (text_byte == CH_LBRACK);
  assign is_close  = (text_byte == CH_RBRACE) || (text_byte == CH_RBRACK);
  assign is_quote  = (text_byte == CH_QUOTE);
  assign is_ws     = (text_byte == CH_TAB) || (text_byte == CH_CR) || (text_byte == CH_NL) ||
                     (text_byte == CH_SPACE) || (text_byte == CH_COLON) ||
                     (text_byte == CH_COMMA);
  assign ends_prim = (text_byte == CH_COMMA) || is_close || (text_byte == CH_SPACE) ||
                     (text_byte == CH_NL);
  assign full      = (CW'(slot_r) >= CW'(token_limit)) || (slot_r >= SW'(MAX_TOKENS));

  always_comb begin
    mode_nxt   = mode_r;
    item_nxt   = item_r;
    pos_nxt    = pos_r;
    slot_nxt   = slot_r;
    depth_nxt  = depth_r;
    do_create  = 1'b0;
    ck         = TK_PRIM;
    cs         = item_r;
    ce         = '0;
    close_req  = 1'b0;
    push       = 1'b0;
    grp_c      = '0;
    stk_c      = '0;

    unique case (mode_r)
      MODE_STRING: begin
        if (is_quote) begin
          do_create = 1'b1;
          ck        = TK_STRING;
          ce        = {1'b0, pos_r};
          mode_nxt  = MODE_NORMAL;
        end
      end
      MODE_PRIM: begin
        if (ends_prim) begin
          do_create = 1'b1;
          ce        = {1'b0, pos_r};
          mode_nxt  = MODE_NORMAL;
          close_req = is_close;
        end else if (end_of_text) begin
          do_create = 1'b1;
          ce        = p1;
          mode_nxt  = MODE_NORMAL;
        end
      end
      MODE_NORMAL: begin
        if (is_open) begin
          do_create = 1'b1;
          ck        = (text_byte == CH_LBRACE) ? TK_OBJECT : TK_ARRAY;
          cs        = pos_r;
        end else if (is_close) begin
          close_req = 1'b1;
        end else if (is_quote) begin
          item_nxt = p1[POS_BITS-1:0];
          mode_nxt = MODE_STRING;
        end else if (!is_ws) begin
          if (end_of_text) begin
            do_create = 1'b1;
            cs        = pos_r;
            ce        = p1;
          end else begin
            item_nxt = pos_r;
            mode_nxt = MODE_PRIM;
          end
        end
      end
      MODE_DROP: ;
      default: ;
    endcase

    cknown     = (ck == TK_STRING) || (ck == TK_PRIM);
    fail_slots = do_create && full;
    pop        = close_req && !fail_slots && (depth_r != '0);
    failed     = fail_slots;

    if (do_create) begin
      grp_c.cnt = 2'd1;
      if (fail_slots) begin
        grp_c.recs[0].rkind = RK_ERROR;
        grp_c.recs[0].ecode = ERR_SLOTS;
      end else begin
        grp_c.recs[0].rkind  = RK_TOKEN;
        grp_c.recs[0].idx    = 8'(slot_r);
        grp_c.recs[0].tkind  = ck;
        grp_c.recs[0].spos   = 16'(cs);
        grp_c.recs[0].epos   = cknown ? 17'(ce) : 17'd0;
        grp_c.recs[0].eknown = cknown;
        slot_nxt = slot_r + 1'b1;
        if (!cknown && (depth_r < SW'(MAX_TOKENS))) begin
          push      = 1'b1;
          depth_nxt = depth_r + 1'b1;
        end
      end
    end

    if (pop) begin
      grp_c.recs[grp_c.cnt].rkind  = RK_CLOSE;
      grp_c.recs[grp_c.cnt].epos   = 17'(p1);
      grp_c.recs[grp_c.cnt].eknown = 1'b1;
      stk_c[grp_c.cnt]             = 1'b1;
      grp_c.cnt                    = grp_c.cnt + 1'b1;
      depth_nxt                    = depth_r - 1'b1;
    end

    if (!failed && (mode_nxt != MODE_DROP)) begin
      if (end_of_text) begin
        if (mode_nxt == MODE_STRING) begin
          grp_c.recs[grp_c.cnt].rkind = RK_ERROR;
          grp_c.recs[grp_c.cnt].ecode = ERR_STRING;
          failed = 1'b1;
        end else begin
          grp_c.recs[grp_c.cnt].rkind = RK_DONE;
          grp_c.recs[grp_c.cnt].total = 9'(slot_nxt);
        end
        grp_c.cnt = grp_c.cnt + 1'b1;
      end else if (&pos_r) begin
        grp_c.recs[grp_c.cnt].rkind = RK_ERROR;
        grp_c.recs[grp_c.cnt].ecode = ERR_TOOLONG;
        grp_c.cnt = grp_c.cnt + 1'b1;
        failed = 1'b1;
      end
    end

    if (failed) begin
      mode_nxt = MODE_DROP;
    end
    if (end_of_text) begin
      mode_nxt  = MODE_NORMAL;
      pos_nxt   = '0;
      item_nxt  = '0;
      slot_nxt  = '0;
      depth_nxt = '0;
    end else begin
      pos_nxt = p1[POS_BITS-1:0];
    end
  end

  assign in_ready = !s1_valid_r || grp_ready;
  assign acc      = in_valid && in_ready;

  jbt_ram #(
    .WIDTH (8),
    .DEPTH (MAX_TOKENS)
  ) u_stack (
    .clk   (clk),
    .we    (acc && push),
    .waddr (depth_r[AW-1:0]),
    .wdata (8'(slot_r)),
    .re    (acc && pop),
    .raddr (AW'(depth_r - 1'b1)),
    .rdata (stk_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_NORMAL;
      pos_r      <= '0;
      item_r     <= '0;
      slot_r     <= '0;
      depth_r    <= '0;
      s1_valid_r <= 1'b0;
    end else if (acc) begin
      mode_r     <= mode_nxt;
      pos_r      <= pos_nxt;
      item_r     <= item_nxt;
      slot_r     <= slot_nxt;
      depth_r    <= depth_nxt;
      s1_valid_r <= (grp_c.cnt != 2'd0);
    end else if (grp_ready) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_grp_r <= grp_c;
      s1_stk_r <= stk_c;
    end
  end

  // close records take their slot from the stack read
  always_comb begin
    grp = s1_grp_r;
    for (int i = 0; i < REGS_PER_GRP; i++) begin
      if (s1_stk_r[i]) begin
        grp.recs[i].idx = stk_rdata;
      end
    end
  end

  assign grp_valid = s1_valid_r;

endmodule

>>> rtl/core/jbt_queue.sv
// ----------------------------------------------------------------------------
// jbt_queue
// Short FIFO of record groups between the parser and the output stage.
// ----------------------------------------------------------------------------
module jbt_queue import jbt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_valid,
  output logic     wr_ready,
  input  jbt_grp_t wr_grp,
  output logic     rd_valid,
  input  logic     rd_pop,
  output jbt_grp_t rd_grp
);

  jbt_grp_t          entries_r [QDEPTH];
  logic [QPTR_W-1:0] head_r, head_nxt;
  logic [QPTR_W-1:0] tail_r, tail_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              do_wr, do_rd;

  assign wr_ready = (count_r != QPTR_W'(0) + (QPTR_W+1)'(QDEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_grp   = entries_r[head_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_pop && rd_valid;

  always_comb begin
    head_nxt  = do_rd ? head_r + 1'b1 : head_r;
    tail_nxt  = do_wr ? tail_r + 1'b1 : tail_r;
    count_nxt = count_r + (QPTR_W+1)'(do_wr) - (QPTR_W+1)'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries_r[tail_r] <= wr_grp;
    end
  end

endmodule

>>> rtl/core/jbt_back.sv
// ----------------------------------------------------------------------------
// jbt_back
// Unpacks record groups into single records behind an output register.
// ----------------------------------------------------------------------------
module jbt_back import jbt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     grp_valid,
  input  jbt_grp_t grp,
  output logic     grp_pop,
  output logic     out_valid,
  input  logic     out_ready,
  output jbt_rec_t out_rec,
  output logic     out_last
);

  logic [1:0] sub_r, sub_nxt;
  logic       valid_r, valid_nxt;
  jbt_rec_t   rec_r;
  logic       last_r;
  logic       load, at_last;

  assign load    = grp_valid && (!valid_r || out_ready);
  assign at_last = (sub_r == grp.cnt - 1'b1);
  assign grp_pop = load && at_last;

  always_comb begin
    sub_nxt   = sub_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
      sub_nxt   = at_last ? 2'd0 : sub_r + 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      sub_r   <= sub_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rec_r  <= grp.recs[sub_r];
      last_r <= at_last;
    end
  end

  assign out_valid = valid_r;
  assign out_rec   = rec_r;
  assign out_last  = last_r;

endmodule

>>> rtl/core/json_byte_tokenizer_top.sv
// ----------------------------------------------------------------------------
// json_byte_tokenizer_top
// Byte-serial JSON tokenizer with token record output.
//
// in_ch carries one text byte per transfer, with end_of_text on the last byte
// of a text. out_ch carries token records (created, closed, done, error), up
// to three per byte; last_of_run marks the final record of a byte.
// One byte is taken per cycle unless a full queue holds back the stage register.
// A byte that yields records passes the stage register, the record queue and
// the output register before valid shows on out_ch; a byte with several
// records gives them one by one from the single-record output register.
// Close records read the container stack, a RAM with registered read, whose
// data joins the stage register's group ahead of the record queue.
// A four-group queue decouples the parser from the output; when the receiver
// stalls, the queue fills and in_ch.ready drops.
// Reset clears the parser state, the queue and the output register, and sets
// token_limit to 256. The stack RAM is not cleared; entries are written
// before they are read. token_limit sits at APB address 0; write it only
// while no text is in flight.
// ----------------------------------------------------------------------------
module json_byte_tokenizer_top import jbt_pkg::*; #(
  parameter int MAX_TOKENS = MAX_TOKENS_DEF,
  parameter int POS_BITS   = POS_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  jbt_in_if.sink      in_ch,
  jbt_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [8:0] limit_r;
  logic       grp_valid, grp_ready, q_valid, q_pop;
  jbt_grp_t   grp, q_grp;
  jbt_rec_t   rec;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TOKEN_LIMIT) ? {23'd0, limit_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= TOKEN_LIMIT_RST;
    end else if (psel && penable && pwrite && (paddr[2] == REG_TOKEN_LIMIT)) begin
      limit_r <= pwdata[8:0];
    end
  end

  jbt_front #(
    .MAX_TOKENS (MAX_TOKENS),
    .POS_BITS   (POS_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .text_byte   (in_ch.text_byte),
    .end_of_text (in_ch.end_of_text),
    .token_limit (limit_r),
    .grp_valid   (grp_valid),
    .grp         (grp),
    .grp_ready   (grp_ready)
  );

  jbt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (grp_valid),
    .wr_ready (grp_ready),
    .wr_grp   (grp),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_grp   (q_grp)
  );

  jbt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .grp_valid (q_valid),
    .grp       (q_grp),
    .grp_pop   (q_pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_rec   (rec),
    .out_last  (out_ch.last_of_run)
  );

  assign out_ch.record_kind = rec.rkind;
  assign out_ch.token_index = rec.idx;
  assign out_ch.token_kind  = rec.tkind;
  assign out_ch.start_pos   = rec.spos;
  assign out_ch.end_pos     = rec.epos;
  assign out_ch.end_known   = rec.eknown;
  assign out_ch.token_total = rec.total;
  assign out_ch.error_code  = rec.ecode;

endmodule

>>> tb/json_byte_tokenizer_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// json_byte_tokenizer_top_tb
// Self-checking bench for the JSON byte tokenizer. A queue-fed driver sends
// text bytes; every accepted byte runs through a local tokenizer model that
// queues the expected records. The monitor compares each record transfer field
// by field. Covers directed corner texts, small and full slot limits, nested
// containers and random well-formed and noisy text under three idle/stall
// profiles.
// ----------------------------------------------------------------------------
module json_byte_tokenizer_top_tb;
  import jbt_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 12;
  localparam logic [2:0] LIMIT_ADDR = 3'(REG_TOKEN_LIMIT) * 3'd4;

  typedef enum logic [1:0] {SCAN_NORMAL, SCAN_STRING, SCAN_PRIM, SCAN_DROP} scan_mode_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_beat_t;

  typedef struct packed {
    jbt_rec_t rec;
    logic     last;
  } token_record_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  jbt_in_if  in_ch ();
  jbt_out_if out_ch ();

  json_byte_tokenizer_top u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  text_beat_t    text_q[$];
  token_record_t record_q[$];
  jbt_rec_t      byte_recs[$];
  text_beat_t    drive_beat;
  token_record_t want_rec;

  int unsigned bytes_queued;
  int unsigned bytes_taken;
  int          fail_count;
  int          src_idle_pct;
  int          sink_idle_pct;
  int          stall_cycles;

  // tokenizer model state
  logic [8:0]  slot_limit;
  logic [15:0] cur_pos;
  logic [8:0]  slots_used;
  scan_mode_e  mode;
  logic [15:0] item_begin;
  logic [7:0]  open_slots [MAX_TOKENS_DEF];
  logic [8:0]  open_count;
  logic        err_hit;

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.text_byte = '0;
    in_ch.end_of_text = 1'b0;
    out_ch.ready = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void model_restart();
    cur_pos = '0;
    slots_used = '0;
    mode = SCAN_NORMAL;
    item_begin = '0;
    open_count = '0;
  endfunction

  function automatic void add_rec(logic [1:0] rk, logic [7:0] idx, logic [1:0] tk,
                                  logic [15:0] sp, logic [16:0] ep, logic ek,
                                  logic [8:0] tot, logic [1:0] ec);
    byte_recs.push_back('{rk, idx, tk, sp, ep, ek, tot, ec});
  endfunction

  function automatic void add_error(logic [1:0] code);
    add_rec(RK_ERROR, '0, '0, '0, '0, 1'b0, '0, code);
    err_hit = 1'b1;
  endfunction

  function automatic void new_token(logic [1:0] tk, logic [15:0] sp, logic [16:0] ep,
                                    logic ek);
    logic [8:0] cap;
    cap = (slot_limit > 9'(MAX_TOKENS_DEF)) ? 9'(MAX_TOKENS_DEF) : slot_limit;
    if (slots_used >= cap) begin
      add_error(ERR_SLOTS);
      return;
    end
    add_rec(RK_TOKEN, slots_used[7:0], tk, sp, ep, ek, '0, '0);
    if ((tk == TK_OBJECT || tk == TK_ARRAY) && open_count < 9'(MAX_TOKENS_DEF)) begin
      open_slots[open_count[7:0]] = slots_used[7:0];
      open_count++;
    end
    slots_used++;
  endfunction

  function automatic void scan_normal(logic [7:0] c, logic [15:0] p);
    case (c)
      CH_LBRACE: new_token(TK_OBJECT, p, '0, 1'b0);
      CH_LBRACK: new_token(TK_ARRAY, p, '0, 1'b0);
      CH_RBRACE, CH_RBRACK: begin
        if (open_count != 0) begin
          open_count--;
          add_rec(RK_CLOSE, open_slots[open_count[7:0]], '0, '0, {1'b0, p} + 17'd1, 1'b1,
                  '0, '0);
        end
      end
      CH_QUOTE: begin
        item_begin = p + 16'd1;
        mode = SCAN_STRING;
      end
      CH_TAB, CH_CR, CH_NL, CH_SPACE, CH_COLON, CH_COMMA: ;
      default: begin
        item_begin = p;
        mode = SCAN_PRIM;
      end
    endcase
  endfunction

  // expected records for one accepted byte
  function automatic void tokenize_byte(logic [7:0] c, logic eot);
    logic [15:0] p;
    p = cur_pos;
    byte_recs.delete();
    err_hit = 1'b0;
    case (mode)
      SCAN_STRING: begin
        if (c == CH_QUOTE) begin
          mode = SCAN_NORMAL;
          new_token(TK_STRING, item_begin, {1'b0, p}, 1'b1);
        end
      end
      SCAN_PRIM: begin
        if (c inside {CH_COMMA, CH_RBRACE, CH_RBRACK, CH_SPACE, CH_NL}) begin
          mode = SCAN_NORMAL;
          new_token(TK_PRIM, item_begin, {1'b0, p}, 1'b1);
          if (!err_hit) scan_normal(c, p);
        end
      end
      SCAN_NORMAL: scan_normal(c, p);
      default: ;
    endcase
    if (!err_hit && eot) begin
      if (mode == SCAN_PRIM) begin
        mode = SCAN_NORMAL;
        new_token(TK_PRIM, item_begin, {1'b0, p} + 17'd1, 1'b1);
      end else if (mode == SCAN_STRING) begin
        add_error(ERR_STRING);
      end
    end
    if (!err_hit && mode != SCAN_DROP) begin
      if (eot) add_rec(RK_DONE, '0, '0, '0, '0, 1'b0, slots_used, '0);
      else if (&p) add_error(ERR_TOOLONG);
    end
    if (err_hit) mode = SCAN_DROP;
    if (eot) model_restart();
    else cur_pos = p + 16'd1;
    foreach (byte_recs[i]) record_q.push_back('{byte_recs[i], i == byte_recs.size() - 1});
  endfunction

  function automatic void check_field(string name, logic [16:0] want, logic [16:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        tokenize_byte(in_ch.text_byte, in_ch.end_of_text);
        bytes_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (text_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          drive_beat = text_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.text_byte <= drive_beat.ch;
          in_ch.end_of_text <= drive_beat.last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (record_q.size() == 0) begin
          $error("record with no expectation: record_kind 0x%0h", out_ch.record_kind);
          fail_count++;
        end else begin
          want_rec = record_q.pop_front();
          check_field("record_kind", want_rec.rec.rkind, out_ch.record_kind);
          check_field("token_index", want_rec.rec.idx, out_ch.token_index);
          check_field("token_kind", want_rec.rec.tkind, out_ch.token_kind);
          check_field("start_pos", want_rec.rec.spos, out_ch.start_pos);
          check_field("end_pos", want_rec.rec.epos, out_ch.end_pos);
          check_field("end_known", want_rec.rec.eknown, out_ch.end_known);
          check_field("token_total", want_rec.rec.total, out_ch.token_total);
          check_field("error_code", want_rec.rec.ecode, out_ch.error_code);
          check_field("last_of_run", want_rec.last, out_ch.last_of_run);
        end
      end
      out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic push_byte(logic [7:0] ch, logic last);
    text_q.push_back('{ch, last});
    bytes_queued++;
  endtask

  task automatic push_text(string s, bit ends);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], ends && i == s.len() - 1);
  endtask

  function automatic logic [7:0] content_byte();
    case ($urandom_range(0, 3))
      0:       return 8'(8'h30 + $urandom_range(0, 9));
      1, 2:    return 8'(8'h61 + $urandom_range(0, 25));
      default: return 8'(8'h80 + $urandom_range(0, 127));
    endcase
  endfunction

  function automatic logic [7:0] close_byte();
    return $urandom_range(0, 1) ? CH_RBRACE : CH_RBRACK;
  endfunction

  // mostly well-formed structure with random content, some noise bytes
  task automatic push_random_text();
    logic [7:0] body[$];
    int         depth;
    int         n_elems;
    depth = 0;
    n_elems = $urandom_range(1, 8);
    for (int e = 0; e < n_elems; e++) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          body.push_back($urandom_range(0, 1) ? CH_LBRACE : CH_LBRACK);
          depth++;
        end
        2: begin
          body.push_back(close_byte());
          if (depth > 0) depth--;
        end
        3: begin
          body.push_back(CH_QUOTE);
          repeat ($urandom_range(0, 3)) body.push_back(content_byte());
          if (e != n_elems - 1 || $urandom_range(0, 5) != 0) body.push_back(CH_QUOTE);
        end
        4, 5: begin
          repeat ($urandom_range(1, 3)) body.push_back(content_byte());
        end
        6, 7: begin
          case ($urandom_range(0, 5))
            0:       body.push_back(CH_COMMA);
            1:       body.push_back(CH_COLON);
            2:       body.push_back(CH_SPACE);
            3:       body.push_back(CH_NL);
            4:       body.push_back(CH_TAB);
            default: body.push_back(CH_CR);
          endcase
        end
        default: body.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    while (depth > 0 && $urandom_range(0, 3) != 0) begin
      body.push_back(close_byte());
      depth--;
    end
    foreach (body[i]) push_byte(body[i], i == body.size() - 1);
  endtask

  task automatic push_random_texts(int unsigned n);
    int unsigned target;
    target = bytes_queued + n;
    while (bytes_queued < target) push_random_text();
  endtask

  // hold until every byte is taken and every record has come back
  task automatic settle();
    while (bytes_taken != bytes_queued || record_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_limit(logic [8:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= LIMIT_ADDR;
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    slot_limit = value;
  endtask

  initial begin
    bytes_queued = 0;
    bytes_taken = 0;
    fail_count = 0;
    stall_cycles = 0;
    slot_limit = TOKEN_LIMIT_RST;
    model_restart();
    src_idle_pct = 9;
    sink_idle_pct = 58;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // close on empty stack, string open on last byte, mixed corner text
    push_text("]", 1'b1);
    push_text("\"", 1'b1);
    push_text("{\"a\":[", 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(CH_COMMA, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(CH_TAB, 1'b0);
    push_text(" z]", 1'b1);
    push_byte(CH_CR, 1'b0);
    push_text("q\n5}", 1'b1);
    push_text("\"ab", 1'b1);
    push_random_texts(100);
    settle();

    program_limit(9'd0);
    push_text("x", 1'b1);
    push_text("[1]", 1'b1);
    push_text("  ", 1'b1);
    push_text("\"s\"", 1'b1);
    settle();
    program_limit(9'd2);
    push_text("[1,2]", 1'b1);
    push_text("{\"k\":7", 1'b1);
    settle();

    src_idle_pct = 58;
    sink_idle_pct = 9;
    program_limit(9'd3);
    push_random_texts(100);
    settle();

    src_idle_pct = 0;
    sink_idle_pct = 0;
    program_limit(9'd256);
    repeat (20) push_byte(CH_LBRACK, 1'b0);
    repeat (19) push_byte(CH_RBRACK, 1'b0);
    push_byte(CH_RBRACK, 1'b1);
    push_random_texts(30);
    settle();
    repeat (3) begin
      program_limit(9'($urandom_range(1, 256)));
      push_random_texts(25);
      settle();
    end

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> json_byte_tokenizer_top.f
rtl/core/jbt_pkg.sv
rtl/core/jbt_ifs.sv
rtl/core/jbt_ram.sv
rtl/core/jbt_front.sv
rtl/core/jbt_queue.sv
rtl/core/jbt_back.sv
rtl/core/json_byte_tokenizer_top.sv
tb/json_byte_tokenizer_top_tb.sv
